// ===== src/ldq_pkg.sv =====
// Package for the linear array deque: sizes, operation and status codes,
// controller state type and the structs passed between the submodules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ldq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST       = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_BLOCKED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DATA = 1'b1
    } state_t;

    // One access per cycle: write or read at a single address.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    // Result handed from the controller to the output register.
    typedef struct packed {
        logic    load;
        status_t status;
        logic    from_mem;
        logic    last;
    } res_t;

endpackage

`default_nettype wire

// ===== src/ldq_mem.sv =====
// Single-port synchronous store of DEPTH words, registered read data.
// Depends on ldq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldq_mem
    import ldq_pkg::*;
(
    input  wire logic              clk,
    input  wire mem_req_t          req,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem_array[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/ldq_out.sv =====
// Output register of the deque: holds one result until it is taken.
// Depends on ldq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldq_out
    import ldq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire res_t               res,
    input  wire logic [DATA_W-1:0]  rd_data,
    output logic                    out_free,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [DATA_W-1:0] data,
    output logic                    last
);

    logic              valid_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] data_reg;
    logic              last_reg;

    assign out_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            status_reg <= res.status;
            data_reg   <= res.from_mem ? rd_data : '0;
            last_reg   <= res.last;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== src/ldq_ctrl.sv =====
// Deque controller: front/end indices, operation decode and the sequencer
// that streams stored words to the output. Depends on ldq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldq_ctrl
    import ldq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [DATA_W-1:0]  value,
    input  wire logic               out_free,
    output mem_req_t                mem_req,
    output res_t                    res
);

    localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(DEPTH);
    localparam logic [PTR_W-1:0] ONE_PTR   = PTR_W'(1);

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [PTR_W-1:0] end_reg,   end_next;
    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic             last_reg,  last_next;

    logic             accept;
    logic             empty;
    logic             full;
    logic             fresh;
    logic [PTR_W-1:0] end_dec;
    logic [PTR_W-1:0] front_dec;
    logic [PTR_W-1:0] idx_inc;
    logic             list_first_last;
    logic             list_next_last;

    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign empty     = front_reg >= end_reg;
    assign full      = end_reg == DEPTH_PTR;
    assign fresh     = (front_reg == '0) && (end_reg == '0);
    assign end_dec   = end_reg - ONE_PTR;
    assign front_dec = front_reg - ONE_PTR;
    assign idx_inc   = {{(PTR_W-IDX_W){1'b0}}, idx_reg} + ONE_PTR;

    // Final word of a listing: the next slot reaches the end index.
    assign list_first_last = (front_reg + ONE_PTR) >= end_reg;
    assign list_next_last  = (idx_inc + ONE_PTR) >= end_reg;

    // Next state and index updates.
    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        end_next   = end_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FN_PUSH_REAR:
                        begin
                            if (!full)
                            begin
                                end_next = end_reg + ONE_PTR;
                            end
                        end
                        FN_PUSH_FRONT:
                        begin
                            if (fresh)
                            begin
                                end_next = ONE_PTR;
                            end
                            else if (front_reg != '0)
                            begin
                                front_next = front_dec;
                            end
                        end
                        FN_POP_FRONT:
                        begin
                            if (!empty)
                            begin
                                front_next = front_reg + ONE_PTR;
                                last_next  = 1'b1;
                                state_next = S_DATA;
                            end
                        end
                        FN_POP_REAR:
                        begin
                            if (!empty)
                            begin
                                last_next  = 1'b1;
                                state_next = S_DATA;
                                if (front_reg >= end_dec)
                                begin
                                    front_next = '0;
                                    end_next   = '0;
                                end
                                else
                                begin
                                    end_next = end_dec;
                                end
                            end
                        end
                        FN_LIST:
                        begin
                            if (!empty)
                            begin
                                idx_next   = front_reg[IDX_W-1:0];
                                last_next  = list_first_last;
                                state_next = S_DATA;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_inc[IDX_W-1:0];
                        last_next = list_next_last;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory access and result to the output register.
    always_comb
    begin
        mem_req       = '0;
        mem_req.wdata = value;
        res           = '0;
        res.status    = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res.last = 1'b1;
                    case (func)
                        FN_PUSH_REAR:
                        begin
                            res.load = 1'b1;
                            if (full)
                            begin
                                res.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_req.we   = 1'b1;
                                mem_req.addr = end_reg[IDX_W-1:0];
                            end
                        end
                        FN_PUSH_FRONT:
                        begin
                            res.load = 1'b1;
                            if (fresh)
                            begin
                                mem_req.we   = 1'b1;
                                mem_req.addr = '0;
                            end
                            else if (front_reg != '0)
                            begin
                                mem_req.we   = 1'b1;
                                mem_req.addr = front_dec[IDX_W-1:0];
                            end
                            else
                            begin
                                res.status = ST_BLOCKED;
                            end
                        end
                        FN_POP_FRONT, FN_LIST:
                        begin
                            if (empty)
                            begin
                                res.load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = front_reg[IDX_W-1:0];
                            end
                        end
                        FN_POP_REAR:
                        begin
                            if (empty)
                            begin
                                res.load   = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = end_dec[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                            res.load = 1'b0;
                        end
                    endcase
                end
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    res.load     = 1'b1;
                    res.from_mem = 1'b1;
                    res.last     = last_reg;
                    if (!last_reg)
                    begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = idx_inc[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                res.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            end_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            end_reg   <= end_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/linear_array_deque_core.sv =====
// Top level of the linear array deque: controller, word store and output
// register. Depends on ldq_pkg, ldq_ctrl, ldq_mem and ldq_out.
`timescale 1ns / 1ps
`default_nettype none

// A double-ended queue held in a linear (non-circular) store of DEPTH
// 32-bit words, addressed by a front index and an end index one past the
// rear. func selects push rear, push front, pop front, pop rear or list;
// codes 5 to 7 are taken and ignored with no result. Every operation except
// list returns exactly one result with last set; list returns one result
// per held word from front to rear, last on the final one, or a single
// empty status. Status reports overflow when the rear reaches DEPTH, a
// blocked front push when the front index is zero on a non-empty deque,
// and empty on pops or lists with nothing held; data is zero for pushes
// and for any non-ok status. Timing: a push or any error result is loaded
// into the output register as the item is taken; a successful pop or a list
// first reads the single-port store, whose read data is registered, and takes
// no new item until its last word is loaded. Words stream out one per cycle
// while the output is not stalled. The output register lets the next item be
// taken in the same cycle as a waiting result is transferred. No clearing pass
// is run after reset: the indices alone decide what is held.

module linear_array_deque_core
    import ldq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [DATA_W-1:0]  value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     status,
    output logic signed [DATA_W-1:0]       data,
    output logic                           last
);

    mem_req_t          mem_req;
    res_t              res;
    logic [DATA_W-1:0] rd_data;
    logic              out_free;

    // Decode each transfer, track indices and sequence memory reads.
    ldq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .value    (value),
        .out_free (out_free),
        .mem_req  (mem_req),
        .res      (res)
    );

    // Hold the words; one write or one read per cycle, so a read never
    // meets a write to the same slot in flight.
    ldq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Hold each result until the receiving side transfers it.
    ldq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .rd_data   (rd_data),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== src/ldq_checker.sv =====
// Port-level checks for the linear array deque and their binding to the
// top level. Depends on ldq_pkg and linear_array_deque_core.
`timescale 1ns / 1ps
`default_nettype none

module ldq_checker
    import ldq_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [1:0]                status,
    input wire logic signed [DATA_W-1:0]  data,
    input wire logic                      last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(data) && $stable(last))
        else $error("stalled result changed");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> last)
        else $error("error status without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (data == '0))
        else $error("error status with nonzero data");

endmodule

bind linear_array_deque_core ldq_checker u_ldq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data      (data),
    .last      (last)
);

`default_nettype wire

// ===== sim/linear_array_deque_core_test.sv =====
// Self-checking testbench for linear_array_deque_core: a directed table, then random traffic
// with random idling on both channels. Results are checked against an in-bench deque model,
// or against a typed row's own result. Depends on ldq_pkg and the RTL under src.
`timescale 1ns / 1ps

module linear_array_deque_core_test;

    import ldq_pkg::*;

    // Selectors that the block takes and drops without any result
    localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 170;
    localparam int DRAIN_CYCLES  = 40;   // longer than a full list plus output register
    localparam int NUM_ROWS      = 24;

    // Phases of the random part, each one biased toward a region of the deque
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_REFILL = 2;
    localparam int PH_MIXED  = 3;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } deque_result_t;

    // One row of the directed table; a typed row carries its one result as written here
    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] val;
        logic [4:0]        reps;
        logic              typed;
        status_t           st;
        logic [DATA_W-1:0] dat;
    } stim_row_t;

    stim_row_t stim_rows [NUM_ROWS] = '{
        // empty deque straight out of reset
        '{FN_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,    32'h0000_0000},
        '{FN_POP_REAR,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,    32'h0000_0000},
        '{FN_LIST,       32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,    32'h0000_0000},
        // front push into the reset deque lands in slot 0, then is blocked
        '{FN_PUSH_FRONT, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,       32'h0000_0000},
        '{FN_PUSH_FRONT, 32'h8000_0000, 5'd1,  1'b1, ST_BLOCKED,  32'h0000_0000},
        '{FN_PUSH_REAR,  32'h8000_0000, 5'd1,  1'b1, ST_OK,       32'h0000_0000},
        '{FN_PUSH_REAR,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,       32'h0000_0000},
        '{FN_PUSH_REAR,  32'h0000_0000, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        '{FN_LIST,       32'h0000_0000, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        '{FN_POP_FRONT,  32'h0000_0000, 5'd1,  1'b1, ST_OK,       32'h7FFF_FFFF},
        '{FN_PUSH_FRONT, 32'h5555_5555, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        // drain from the front: indices stay where they are
        '{FN_POP_FRONT,  32'h0000_0000, 5'd4,  1'b0, ST_OK,       32'h0000_0000},
        '{FN_LIST,       32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,    32'h0000_0000},
        '{FN_POP_REAR,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,    32'h0000_0000},
        // front push into a front-drained deque goes below the old front
        '{FN_PUSH_FRONT, 32'hAAAA_AAAA, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        // unused selectors produce nothing
        '{FN_RSVD5,      32'hFFFF_FFFF, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        '{FN_RSVD6,      32'h0000_0000, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        '{FN_RSVD7,      32'h8000_0000, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        // rear pop that empties the deque resets both indices
        '{FN_POP_REAR,   32'h0000_0000, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        '{FN_PUSH_FRONT, 32'h1234_5678, 5'd1,  1'b0, ST_OK,       32'h0000_0000},
        // fill to DEPTH, then overflow and a blocked front push, then list all
        '{FN_PUSH_REAR,  32'h0000_0000, 5'd15, 1'b0, ST_OK,       32'h0000_0000},
        '{FN_PUSH_REAR,  32'h0000_0000, 5'd1,  1'b1, ST_OVERFLOW, 32'h0000_0000},
        '{FN_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b1, ST_BLOCKED,  32'h0000_0000},
        '{FN_LIST,       32'h0000_0000, 5'd1,  1'b0, ST_OK,       32'h0000_0000}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;

    // Row tag that travels with the payload, so the checker sees it at the same edge
    logic                     row_typed;
    status_t                  row_status;
    logic [DATA_W-1:0]        row_data;

    // Deque model state
    logic [DATA_W-1:0]        model_words [DEPTH];
    logic [PTR_W-1:0]         model_front;
    logic [PTR_W-1:0]         model_end;

    deque_result_t            due_results [$];

    int                       cycle_count;
    int                       stall_left;
    int                       fail_count;
    int                       ops_sent;
    int                       directed_ops;
    int                       results_seen;
    int                       list_run;
    int                       longest_list;
    int                       status_tally [4];
    logic                     calm;

    linear_array_deque_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Quiet stretches: no idling on either side while cycle_count[8:7] is zero, a quarter of the time
    assign calm = (cycle_count[8:7] == 2'b00);

    // Pick an idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Bias the data word toward the extremes now and then
    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h7FFF_FFFF;
        else if (r < 16)
            return 32'h8000_0000;
        else if (r < 20)
            return 32'h0000_0000;
        else if (r < 24)
            return 32'hFFFF_FFFF;
        else
            return $urandom();
    endfunction

    // Pick an operation for the current phase; a few percent are unused selectors
    function automatic logic [FUNC_W-1:0] pick_op(input int phase);
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 4)
            return FUNC_W'($urandom_range(FN_RSVD5, FN_RSVD7));
        case (phase)
            PH_GROW:
                if (r < 55)      return FN_PUSH_REAR;
                else if (r < 70) return FN_PUSH_FRONT;
                else if (r < 80) return FN_POP_FRONT;
                else if (r < 88) return FN_POP_REAR;
                else             return FN_LIST;
            PH_SHRINK:
                if (r < 10)      return FN_PUSH_REAR;
                else if (r < 15) return FN_PUSH_FRONT;
                else if (r < 50) return FN_POP_FRONT;
                else if (r < 85) return FN_POP_REAR;
                else             return FN_LIST;
            PH_REFILL:
                if (r < 45)      return FN_POP_FRONT;
                else if (r < 80) return FN_PUSH_FRONT;
                else if (r < 90) return FN_PUSH_REAR;
                else             return FN_LIST;
            default:
                return FUNC_W'($urandom_range(FN_PUSH_REAR, FN_LIST));
        endcase
    endfunction

    // Apply one operation to the model deque and queue the results it owes
    task automatic apply_deque_op(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
        logic          is_empty;
        deque_result_t r;
        int            i;
        is_empty = (model_front >= model_end);
        r = '{status: ST_OK, data: '0, last: 1'b1};
        case (f)
            FN_PUSH_REAR:
            begin
                if (model_end >= DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    model_words[model_end[IDX_W-1:0]] = v;
                    model_end = model_end + 1'b1;
                end
                due_results.push_back(r);
            end
            FN_PUSH_FRONT:
            begin
                if (model_front == 0 && model_end == 0)
                begin
                    model_words[0] = v;
                    model_end = 1;
                end
                else if (model_front != 0 && model_front <= DEPTH)
                begin
                    model_front = model_front - 1'b1;
                    model_words[model_front[IDX_W-1:0]] = v;
                end
                else
                    r.status = ST_BLOCKED;
                due_results.push_back(r);
            end
            FN_POP_FRONT:
            begin
                if (is_empty || model_front >= DEPTH)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data = model_words[model_front[IDX_W-1:0]];
                    model_front = model_front + 1'b1;
                end
                due_results.push_back(r);
            end
            FN_POP_REAR:
            begin
                if (is_empty || model_end > DEPTH)
                    r.status = ST_EMPTY;
                else
                begin
                    model_end = model_end - 1'b1;
                    r.data = model_words[model_end[IDX_W-1:0]];
                    if (model_front >= model_end)
                    begin
                        model_front = '0;
                        model_end   = '0;
                    end
                end
                due_results.push_back(r);
            end
            FN_LIST:
            begin
                if (is_empty)
                begin
                    r.status = ST_EMPTY;
                    due_results.push_back(r);
                end
                else
                begin
                    for (i = model_front; i < model_end && i < DEPTH; i++)
                    begin
                        r.data = model_words[i];
                        r.last = (i + 1 >= model_end) || (i + 1 >= DEPTH);
                        due_results.push_back(r);
                    end
                end
            end
            default:
            begin
                // unused selector: no result, no state change
            end
        endcase
    endtask

    // Present one item and hold it until the block takes the transfer
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
                           input logic typed, input status_t st, input logic [DATA_W-1:0] dat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        value      <= v;
        row_typed  <= typed;
        row_status <= st;
        row_data   <= dat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f <= FN_LIST)
            ops_sent++;
    endtask

    // Drive stimulus: reset, walk the directed table, then random phases, then drain
    initial
    begin : stimulus
        int row;
        int k;
        int phase;
        int span;
        int random_ops;
        logic [FUNC_W-1:0] f;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FN_PUSH_REAR;
        value      = '0;
        row_typed  = 1'b0;
        row_status = ST_OK;
        row_data   = '0;
        fail_count = 0;
        ops_sent   = 0;
        results_seen = 0;
        list_run   = 0;
        longest_list = 0;
        status_tally = '{0, 0, 0, 0};
        model_front = '0;
        model_end   = '0;
        for (k = 0; k < DEPTH; k++)
            model_words[k] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < NUM_ROWS; row++)
        begin
            for (k = 0; k < stim_rows[row].reps; k++)
            begin
                send_op(stim_rows[row].fn,
                        (stim_rows[row].reps > 1) ? $urandom() : stim_rows[row].val,
                        stim_rows[row].typed, stim_rows[row].st, stim_rows[row].dat);
            end
        end
        directed_ops = ops_sent;

        random_ops = 0;
        while (random_ops < RANDOM_ITEMS)
        begin
            phase = $urandom_range(PH_GROW, PH_MIXED);
            span  = $urandom_range(8, 30);
            for (k = 0; k < span && random_ops < RANDOM_ITEMS; k++)
            begin
                f = pick_op(phase);
                send_op(f, pick_word(), 1'b0, ST_OK, '0);
                if (f <= FN_LIST)
                    random_ops++;
            end
        end
        in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations (%0d from the directed table), checked %0d results.",
                 ops_sent, directed_ops, results_seen);
        $display("Status counts: ok %0d, overflow %0d, blocked %0d, empty %0d; longest list %0d.",
                 status_tally[ST_OK], status_tally[ST_OVERFLOW], status_tally[ST_BLOCKED],
                 status_tally[ST_EMPTY], longest_list);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Output side: stall in bursts of random length
    always @(posedge clk)
    begin : result_pacing
        int g;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            g = pick_gap();
            out_stall  <= (g > 0);
            stall_left <= (g > 0) ? g - 1 : 0;
        end
    end

    // Predict on every input transfer, then check every output transfer in order
    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        deque_result_t typed_want;
        if (rst_n && in_valid && !in_stall)
        begin
            apply_deque_op(func, value);
            // Typed rows carry their single result by hand; swap it in for the predicted one
            if (row_typed && func <= FN_LIST)
            begin
                typed_want = '{status: row_status, data: row_data, last: 1'b1};
                void'(due_results.pop_back());
                due_results.push_back(typed_want);
            end
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            status_tally[status]++;
            list_run = list_run + 1;
            if (list_run > longest_list)
                longest_list = list_run;
            if (last)
                list_run = 0;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d data %h last %b",
                         $time, status, data, last);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, status);
                    fail_count++;
                end
                if (data !== want.data)
                begin
                    $display("%0t: data mismatch, expected %h, got %h", $time, want.data, data);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %b, got %b", $time, want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
